// File: rtl/core/ptt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptt_pkg;

  // table geometry
  localparam int PTT_SLOTS = 16;

  // field widths
  localparam int NONCE_W = 64;
  localparam int PEER_W  = 16;
  localparam int TIME_W  = 48;
  localparam int LEN_W   = 11;
  localparam int VER_W   = 32;
  localparam int RETRY_W = 4;
  localparam int IVL_W   = 16;
  localparam int CMD_W   = 2;
  localparam int KIND_W  = 3;

  // stream and config port widths
  localparam int IN_DATA_W  = 176;
  localparam int OUT_DATA_W = 160;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // input commands
  localparam logic [CMD_W-1:0] CMD_SEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PONG = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;
  localparam logic [CMD_W-1:0] CMD_PING = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_PING    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PONG    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MATCH   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TIMEOUT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FULL    = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_IVL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION   = 2'd2;

  // configuration reset values
  localparam logic [IVL_W-1:0]          RST_RETRY_IVL = 16'd1000;
  localparam logic [RETRY_W-1:0]        RST_MAX_RETRY = 4'd3;
  localparam logic signed [VER_W-1:0]   RST_VERSION   = 32'sd1;

  // minimum wire sizes of received packets
  localparam logic [LEN_W-1:0] PING_WIRE = 11'd9;
  localparam logic [LEN_W-1:0] PONG_WIRE = 11'd13;

  typedef struct packed {
    logic [IVL_W-1:0]        retry_ivl;
    logic [RETRY_W-1:0]      max_retry;
    logic signed [VER_W-1:0] version;
  } cfg_t;

  typedef struct packed {
    logic [NONCE_W-1:0] nonce;
    logic [PEER_W-1:0]  peer;
    logic [TIME_W-1:0]  sent;
    logic [RETRY_W-1:0] retry;
  } slot_t;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [NONCE_W-1:0]      nonce;
    logic [PEER_W-1:0]       peer;
    logic [TIME_W-1:0]       rtt;
    logic signed [VER_W-1:0] version;
  } res_t;

  // engine to output stage: push a result, or close the item
  typedef struct packed {
    logic push;
    logic finish;
    res_t res;
  } emit_t;

endpackage

`default_nettype wire

// File: rtl/core/ptt_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module ptt_cfg_regs
  import ptt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  index,
  input  wire logic [CFG_DATA_W-1:0] data,
  output cfg_t                       cfg
);

  cfg_t cfg_r;

  // write the addressed register, ignore indexes beyond the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.retry_ivl <= RST_RETRY_IVL;
      cfg_r.max_retry <= RST_MAX_RETRY;
      cfg_r.version   <= RST_VERSION;
    end else if (wr_en) begin
      unique case (index)
        CFG_RETRY_IVL: cfg_r.retry_ivl <= data[IVL_W-1:0];
        CFG_MAX_RETRY: cfg_r.max_retry <= data[RETRY_W-1:0];
        CFG_VERSION:   cfg_r.version   <= $signed(data[VER_W-1:0]);
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: rtl/core/ptt_slot_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module ptt_slot_mem
  import ptt_pkg::*;
#(
  parameter int DEPTH = PTT_SLOTS,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  slot_t              wdata,
  input  wire logic [AW-1:0] raddr,
  output slot_t              rdata
);

  slot_t mem [DEPTH];
  slot_t rdata_r;

  // one write port, one registered read port (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/core/ptt_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module ptt_out_stage
  import ptt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  emit_t                      emit,
  output logic                       ok,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic [KIND_W-1:0]          out_tuser,
  output logic                       out_tlast
);

  logic hold_v_r;
  logic out_v_r;
  res_t hold_r;
  res_t out_res_r;
  logic out_last_r;
  logic free;
  logic move;

  // a result waits in hold until the next one shows whether it is the last
  assign free = !out_v_r || out_tready;
  assign ok   = !hold_v_r || free;
  assign move = hold_v_r && ok && (emit.push || emit.finish);

  // control: hold and output valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (move) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (emit.push && ok) begin
        hold_v_r <= 1'b1;
      end else if (emit.finish && ok) begin
        hold_v_r <= 1'b0;
      end
    end
  end

  // payload: shift hold into the output register, load hold
  always_ff @(posedge clk) begin
    if (move) begin
      out_res_r  <= hold_r;
      out_last_r <= emit.finish;
    end
    if (emit.push && ok) begin
      hold_r <= emit.res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_res_r.version, out_res_r.rtt, out_res_r.peer, out_res_r.nonce};
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// File: rtl/core/ptt_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module ptt_engine
  import ptt_pkg::*;
#(
  parameter int SLOTS = PTT_SLOTS,
  localparam int AW   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [CMD_W-1:0]    in_cmd,
  input  wire logic [NONCE_W-1:0]  in_nonce,
  input  wire logic [PEER_W-1:0]   in_peer,
  input  wire logic [TIME_W-1:0]   in_now,
  input  wire logic [LEN_W-1:0]    in_len,
  input  wire logic signed [VER_W-1:0] in_pver,
  input  cfg_t                     cfg,
  output emit_t                    emit,
  input  wire logic                out_ok,
  output logic                     mem_we,
  output logic [AW-1:0]            mem_waddr,
  output slot_t                    mem_wdata,
  output logic [AW-1:0]            mem_raddr,
  input  slot_t                    mem_rdata
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SCAN2 = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [SLOTS-1:0] active_r, active_nxt;
  logic [SLOTS-1:0] expired_r, expired_nxt;

  logic [CMD_W-1:0]        cmd_r;
  logic [NONCE_W-1:0]      nonce_r;
  logic [PEER_W-1:0]       peer_r;
  logic [TIME_W-1:0]       now_r;
  logic signed [VER_W-1:0] pver_r;

  logic              last_idx;
  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] rtt;
  logic              due;
  logic              spent;

  // per-slot arithmetic on the entry read last cycle
  assign last_idx = (idx_r == AW'(SLOTS - 1));
  assign elapsed  = now_r - mem_rdata.sent;
  assign rtt      = (now_r >= mem_rdata.sent) ? elapsed : '0;
  assign due      = active_r[idx_r] && (elapsed >= TIME_W'(cfg.retry_ivl));
  assign spent    = (mem_rdata.retry >= cfg.max_retry);

  assign in_ready  = (state_r == ST_IDLE);
  assign mem_waddr = idx_r;
  // the next slot's entry is fetched while this one is worked on
  assign mem_raddr = idx_nxt;

  // scan sequencer
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    active_nxt  = active_r;
    expired_nxt = expired_r;
    emit        = '0;
    mem_we      = 1'b0;
    mem_wdata   = '{nonce: nonce_r, peer: peer_r, sent: now_r, retry: '0};

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_cmd) inside
            CMD_SEND, CMD_TICK: state_nxt = ST_SCAN;
            CMD_PONG: state_nxt = (in_len >= PONG_WIRE) ? ST_SCAN : ST_FLUSH;
            CMD_PING: begin
              if (in_len >= PING_WIRE) begin
                emit.push = 1'b1;
                emit.res  = '{kind: KIND_PONG, nonce: in_nonce, peer: in_peer,
                              rtt: '0, version: cfg.version};
              end
              state_nxt = ST_FLUSH;
            end
            default: state_nxt = ST_FLUSH;
          endcase
        end
      end

      ST_SCAN: begin
        unique case (cmd_r)
          // claim the lowest free slot, or report a full table
          CMD_SEND: begin
            if (!active_r[idx_r]) begin
              emit.push = 1'b1;
              emit.res  = '{kind: KIND_PING, nonce: nonce_r, peer: peer_r,
                            rtt: '0, version: '0};
              if (out_ok) begin
                mem_we              = 1'b1;
                active_nxt[idx_r]   = 1'b1;
                state_nxt           = ST_FLUSH;
                idx_nxt             = '0;
              end
            end else if (last_idx) begin
              emit.push = 1'b1;
              emit.res  = '{kind: KIND_FULL, nonce: nonce_r, peer: peer_r,
                            rtt: '0, version: '0};
              if (out_ok) begin
                state_nxt = ST_FLUSH;
                idx_nxt   = '0;
              end
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
          // free the lowest active slot with a matching nonce
          CMD_PONG: begin
            if (active_r[idx_r] && (mem_rdata.nonce == nonce_r)) begin
              emit.push = 1'b1;
              emit.res  = '{kind: KIND_MATCH, nonce: nonce_r, peer: peer_r,
                            rtt: rtt, version: pver_r};
              if (out_ok) begin
                active_nxt[idx_r] = 1'b0;
                state_nxt         = ST_FLUSH;
                idx_nxt           = '0;
              end
            end else if (last_idx) begin
              state_nxt = ST_FLUSH;
              idx_nxt   = '0;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
          // resend due slots, mark spent ones for the timeout pass
          CMD_TICK: begin
            emit.res = '{kind: KIND_PING, nonce: mem_rdata.nonce, peer: mem_rdata.peer,
                         rtt: '0, version: '0};
            emit.push = due && !spent;
            if (!emit.push || out_ok) begin
              if (due && spent) begin
                active_nxt[idx_r]  = 1'b0;
                expired_nxt[idx_r] = 1'b1;
              end else if (due) begin
                mem_we    = 1'b1;
                mem_wdata = '{nonce: mem_rdata.nonce, peer: mem_rdata.peer,
                              sent: now_r, retry: mem_rdata.retry + 1'b1};
              end
              if (last_idx) begin
                state_nxt = ST_SCAN2;
                idx_nxt   = '0;
              end else begin
                idx_nxt = idx_r + 1'b1;
              end
            end
          end
          default: begin
            state_nxt = ST_FLUSH;
            idx_nxt   = '0;
          end
        endcase
      end

      // report timeouts in slot order
      ST_SCAN2: begin
        emit.res  = '{kind: KIND_TIMEOUT, nonce: mem_rdata.nonce, peer: mem_rdata.peer,
                      rtt: '0, version: '0};
        emit.push = expired_r[idx_r];
        if (!emit.push || out_ok) begin
          expired_nxt[idx_r] = 1'b0;
          if (last_idx) begin
            state_nxt = ST_FLUSH;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      // release the held result as the last one of the item
      ST_FLUSH: begin
        emit.finish = 1'b1;
        if (out_ok) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
        idx_nxt   = '0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      idx_r     <= '0;
      active_r  <= '0;
      expired_r <= '0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      active_r  <= active_nxt;
      expired_r <= expired_nxt;
    end
  end

  // latch the accepted item
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r   <= in_cmd;
      nonce_r <= in_nonce;
      peer_r  <= in_peer;
      now_r   <= in_now;
      pver_r  <= in_pver;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ping_retry_timeout_tracker_unit.sv
// Ping retry and timeout tracker.
// Input channel in_*: one command per item (in_tuser: send ping, pong received,
// tick, ping received) with nonce, peer, time, packet length and peer version
// in in_tdata. Result channel out_*: zero or more result items per command,
// out_tlast on the final one; kind in out_tuser. Config port cfg_*: write
// retry interval, retry limit and protocol version while the block is idle.
// One item is worked on at a time. The table lives in a one-port-read memory
// that is walked one slot per cycle unless tready low holds a result back; per command:
//   ping received or short packet: no scan
//   send ping / pong received: scan up to the first hit, at most SLOTS slots
//   tick: two passes over all SLOTS slots (resend pass, then timeout pass)
// A result leaves through a hold register and an output register, so it
// shows up one result (or the end of the item) after it is found; tready low
// stalls the scan.
// Reset clears the slot valid bits and the output stage at once; there is no
// memory clearing pass, and the block is ready in the cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module ping_retry_timeout_tracker_unit
  import ptt_pkg::*;
#(
  parameter int SLOTS = PTT_SLOTS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // nonce[63:0], peer[79:64], now_ms[127:80], packet_length[138:128],
  // peer_version[170:139], zero fill above
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // cmd[1:0]
  input  wire logic [CMD_W-1:0]      in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // out_nonce[63:0], out_peer[79:64], rtt_ms[127:80], out_version[159:128]
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // kind[2:0]
  output logic [KIND_W-1:0]          out_tuser,
  output logic                       out_tlast,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  cfg_t          cfg;
  emit_t         emit;
  logic          out_ok;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  slot_t         mem_wdata;
  slot_t         mem_rdata;

  ptt_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (cfg_wr_en),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  ptt_slot_mem #(.DEPTH(SLOTS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ptt_engine #(.SLOTS(SLOTS)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tuser),
    .in_nonce  (in_tdata[63:0]),
    .in_peer   (in_tdata[79:64]),
    .in_now    (in_tdata[127:80]),
    .in_len    (in_tdata[138:128]),
    .in_pver   ($signed(in_tdata[170:139])),
    .cfg       (cfg),
    .emit      (emit),
    .out_ok    (out_ok),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  ptt_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .emit       (emit),
    .ok         (out_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// File: rtl/core/ptt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ptt_checker
  import ptt_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic [KIND_W-1:0]     out_tuser,
  input wire logic                  out_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // one item at a time: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is at work");

  // only defined kinds leave the block
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser <= KIND_FULL))
    else $error("undefined result kind");

  // table full, pong reply and match are the sole result of their item
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tuser == KIND_FULL) || (out_tuser == KIND_PONG) ||
      (out_tuser == KIND_MATCH)) |-> out_tlast)
    else $error("single-result kind without last flag");

endmodule

bind ping_retry_timeout_tracker_unit ptt_checker u_ptt_checker (.*);

`default_nettype wire
